FILE: rtl/wlgs_pkg.sv
// ----------------------------------------------------------------------------
// wlgs_pkg: shared definitions of the word logic gather/scatter unit
// Word width, command codes and the result word type.
// ----------------------------------------------------------------------------
package wlgs_pkg;

  localparam int unsigned WordW = 48;
  localparam int unsigned CmdW  = 3;
  // Bit counter wide enough to index every word bit and to hold a popcount.
  localparam int unsigned CntW  = $clog2(WordW + 1);

  localparam logic [CmdW-1:0] CMD_AND    = 3'd0;
  localparam logic [CmdW-1:0] CMD_OR     = 3'd1;
  localparam logic [CmdW-1:0] CMD_XOR    = 3'd2;
  localparam logic [CmdW-1:0] CMD_CADD   = 3'd3;
  localparam logic [CmdW-1:0] CMD_PACK   = 3'd4;
  localparam logic [CmdW-1:0] CMD_UNPACK = 3'd5;
  localparam logic [CmdW-1:0] CMD_POPADD = 3'd6;
  localparam logic [CmdW-1:0] CMD_NOP    = 3'd7;

  typedef struct packed {
    logic [WordW-1:0] acc;
    logic [WordW-1:0] ext;
  } result_t;

endpackage

FILE: rtl/wlgs_bit_engine.sv
// ----------------------------------------------------------------------------
// wlgs_bit_engine: bit-serial walker and shared adder
// Walks the 48 word or mask bits one per cycle for pack, unpack and popcount;
// the cyclic and popcount adds run end-around-carry on one adder in two steps.
// ----------------------------------------------------------------------------
module wlgs_bit_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [wlgs_pkg::CmdW-1:0]           command_i,
  input  logic [wlgs_pkg::WordW-1:0]          acc_value_i,
  input  logic [wlgs_pkg::WordW-1:0]          operand_i,
  output logic                                idle_o,
  output logic                                done_o,
  input  logic                                take_i,
  output wlgs_pkg::result_t                   result_o
);

  localparam int unsigned W = wlgs_pkg::WordW;
  localparam int unsigned C = wlgs_pkg::CntW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_WRAP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [C-1:0] LastBit = C'(W - 1);

  logic [2:0]                  state_q, state_d;
  logic [wlgs_pkg::CmdW-1:0]   cmd_q, cmd_d;
  logic [C-1:0]                cnt_q, cnt_d;
  logic [C-1:0]                ones_q, ones_d;
  logic                        carry_q, carry_d;
  logic [W-1:0]                a_q, a_d;
  logic [W-1:0]                b_q, b_d;
  logic [W-1:0]                r_q, r_d;
  logic [W-1:0]                ext_q, ext_d;
  logic [W:0]                  sum;

  // The one wide adder: operand add in the first step, carry wrap in the next.
  always_comb begin
    if (state_q == S_WRAP) begin
      sum = {1'b0, r_q} + {{W{1'b0}}, carry_q};
    end else begin
      sum = {1'b0, a_q} + {1'b0, b_q};
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    ones_d  = ones_q;
    carry_d = carry_q;
    a_d     = a_q;
    b_d     = b_q;
    r_d     = r_q;
    ext_d   = ext_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d  = command_i;
          a_d    = acc_value_i;
          b_d    = operand_i;
          cnt_d  = '0;
          ones_d = '0;
          r_d    = '0;
          ext_d  = (command_i == wlgs_pkg::CMD_XOR) ? acc_value_i : '0;
          unique case (command_i)
            wlgs_pkg::CMD_AND: begin
              r_d     = acc_value_i & operand_i;
              state_d = S_DONE;
            end
            wlgs_pkg::CMD_OR: begin
              r_d     = acc_value_i | operand_i;
              state_d = S_DONE;
            end
            wlgs_pkg::CMD_XOR: begin
              r_d     = acc_value_i ^ operand_i;
              state_d = S_DONE;
            end
            wlgs_pkg::CMD_CADD: begin
              state_d = S_ADD;
            end
            wlgs_pkg::CMD_PACK, wlgs_pkg::CMD_UNPACK, wlgs_pkg::CMD_POPADD: begin
              state_d = S_WALK;
            end
            default: begin
              r_d     = acc_value_i;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        unique case (cmd_q)
          wlgs_pkg::CMD_PACK: begin
            // Low bits first; each selected bit enters at the top.
            if (b_q[0]) begin
              r_d = {a_q[0], r_q[W-1:1]};
            end
            a_d = {1'b0, a_q[W-1:1]};
            b_d = {1'b0, b_q[W-1:1]};
          end
          wlgs_pkg::CMD_UNPACK: begin
            // High mask bits first; a source bit is used up only at a mask one.
            r_d = {r_q[W-2:0], b_q[W-1] & a_q[W-1]};
            if (b_q[W-1]) begin
              a_d = {a_q[W-2:0], 1'b0};
            end
            b_d = {b_q[W-2:0], 1'b0};
          end
          default: begin
            ones_d = ones_q + C'(a_q[0]);
            a_d    = {1'b0, a_q[W-1:1]};
          end
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          if (cmd_q == wlgs_pkg::CMD_POPADD) begin
            a_d     = {{(W-C){1'b0}}, ones_d};
            state_d = S_ADD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ADD: begin
        r_d     = sum[W-1:0];
        carry_d = sum[W];
        state_d = S_WRAP;
      end
      S_WRAP: begin
        r_d     = sum[W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cnt_q   <= cnt_d;
    ones_q  <= ones_d;
    carry_q <= carry_d;
    a_q     <= a_d;
    b_q     <= b_d;
    r_q     <= r_d;
    ext_q   <= ext_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign result_o.acc = r_q;
  assign result_o.ext = ext_q;

endmodule

FILE: rtl/word_logic_gather_scatter_unit_top.sv
// ----------------------------------------------------------------------------
// word_logic_gather_scatter_unit_top: logical unit of a 48-bit word machine
// AND, OR, XOR, end-around-carry add, bit pack, bit unpack and popcount add.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one word per command: command, accumulator and
//   operand. The output channel returns the new accumulator and the extension
//   word (old accumulator for XOR, zero otherwise). Both are valid/ready.
//   The bit-serial walker handles one of the 48 bits per cycle, and the
//   cyclic add takes two passes through the single 48-bit adder. One command
//   is in the engine at a time, so a new word is taken in the cycle after the
//   previous result moves into the output register. The output register
//   holds a finished result while the receiver stalls; the engine keeps its
//   result until that register frees, and takes no new word meanwhile. Reset
//   empties both.
// ----------------------------------------------------------------------------
module word_logic_gather_scatter_unit_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wlgs_pkg::CmdW-1:0]    command_i,
  input  logic [wlgs_pkg::WordW-1:0]   acc_value_i,
  input  logic [wlgs_pkg::WordW-1:0]   operand_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wlgs_pkg::WordW-1:0]   acc_out_o,
  output logic [wlgs_pkg::WordW-1:0]   extension_out_o
);

  logic              eng_idle;
  logic              eng_done;
  logic              take;
  wlgs_pkg::result_t eng_res;
  wlgs_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;

  wlgs_bit_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && eng_idle),
    .command_i   (command_i),
    .acc_value_i (acc_value_i),
    .operand_i   (operand_i),
    .idle_o      (eng_idle),
    .done_o      (eng_done),
    .take_i      (take),
    .result_o    (eng_res)
  );

  assign take = eng_done && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= eng_res;
    end
  end

  assign in_ready_o      = eng_idle;
  assign out_valid_o     = out_valid_q;
  assign acc_out_o       = out_q.acc;
  assign extension_out_o = out_q.ext;

endmodule

FILE: rtl/wlgs_checker.sv
// ----------------------------------------------------------------------------
// wlgs_checker: port-level assertions for the logic gather/scatter unit
// Watches the top level's channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
module wlgs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [wlgs_pkg::CmdW-1:0]    command_i,
  input logic [wlgs_pkg::WordW-1:0]   acc_value_i,
  input logic [wlgs_pkg::WordW-1:0]   operand_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [wlgs_pkg::WordW-1:0]   acc_out_o,
  input logic [wlgs_pkg::WordW-1:0]   extension_out_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result word holds its value and stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(acc_out_o)
      && $stable(extension_out_o))
    else $error("stalled output word changed");

  // The engine works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a word is in progress");

  // AND with a free output gives acc AND operand and a zero extension.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && command_i == wlgs_pkg::CMD_AND && !out_valid_o |-> ##2
      (out_valid_o && acc_out_o == ($past(acc_value_i, 2) & $past(operand_i, 2))
       && extension_out_o == '0))
    else $error("AND result wrong or late");

  // XOR returns the old accumulator as the extension word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && command_i == wlgs_pkg::CMD_XOR && !out_valid_o |-> ##2
      (out_valid_o && extension_out_o == $past(acc_value_i, 2)
       && acc_out_o == ($past(acc_value_i, 2) ^ $past(operand_i, 2))))
    else $error("XOR result or extension wrong");

endmodule

bind word_logic_gather_scatter_unit_top wlgs_checker u_wlgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .acc_value_i     (acc_value_i),
  .operand_i       (operand_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .acc_out_o       (acc_out_o),
  .extension_out_o (extension_out_o)
);
